>>> hw/rtl/brfp_pkg.sv
// Shared types and constants for the byte ring FIFO with peek.
package brfp_pkg;

    // Widths fixed by the word fields.
    localparam int unsigned CNT_W = 11;
    localparam int unsigned REQ_W = 7;
    localparam int unsigned OFF_W = 10;
    localparam int unsigned BYTE_W = 8;

    // Action codes on the input and kind codes on the output share one encoding.
    typedef enum logic [1:0] {
        KIND_PUT    = 2'd0,
        KIND_GET    = 2'd1,
        KIND_PEEK   = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    // Command passed from the front part to the back part.
    typedef struct packed {
        kind_t              kind;
        logic               is_read;
        logic [REQ_W-1:0]   count;
        logic [CNT_W-1:0]   amount;
        logic [CNT_W-1:0]   free;
    } cmd_t;

endpackage

>>> hw/rtl/brfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brfp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a read at a written address returns the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/brfp_front.sv
// Front part: accepts words, keeps the pointers, writes put bytes and issues commands.
module brfp_front #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned MAX_RUN = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [brfp_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          put_last,
    input  logic [brfp_pkg::REQ_W-1:0]    request_count,
    input  logic [brfp_pkg::OFF_W-1:0]    peek_offset,
    input  logic                          q_full,
    input  logic                          read_busy,
    output logic                          push,
    output brfp_pkg::cmd_t                cmd,
    output logic [$clog2(DEPTH)-1:0]      cmd_addr,
    output logic                          wr_en,
    output logic [$clog2(DEPTH)-1:0]      wr_addr,
    output logic [brfp_pkg::BYTE_W-1:0]   wr_data
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned PTR_W = AW + 1;

    logic [PTR_W-1:0]           wp_reg;
    logic [PTR_W-1:0]           wp_next;
    logic [PTR_W-1:0]           rp_reg;
    logic [PTR_W-1:0]           rp_next;
    logic [brfp_pkg::CNT_W-1:0] run_cnt_reg;
    logic [brfp_pkg::CNT_W-1:0] run_cnt_next;

    brfp_pkg::kind_t            act;
    logic                       accept;
    logic [PTR_W-1:0]           used;
    logic                       full;
    logic [31:0]                used32;
    logic [31:0]                req32;
    logic [31:0]                n32;
    logic [brfp_pkg::REQ_W-1:0] n;
    logic [31:0]                off32;
    logic [31:0]                peek_sum;
    logic                       peek_hit;
    logic [brfp_pkg::CNT_W-1:0] cnt_inc;
    logic [brfp_pkg::CNT_W-1:0] ack_cnt;
    logic [PTR_W-1:0]           used_after;
    logic [31:0]                free32;

    // Occupancy and the quantities derived from it.
    always_comb
    begin
        act      = brfp_pkg::kind_t'(action);
        used     = wp_reg - rp_reg;
        full     = (used == PTR_W'(DEPTH));
        used32   = 32'(used);
        req32    = (32'(request_count) > 32'(MAX_RUN)) ? 32'(MAX_RUN) : 32'(request_count);
        n32      = (req32 > used32) ? used32 : req32;
        n        = n32[brfp_pkg::REQ_W-1:0];
        off32    = 32'(peek_offset);
        peek_hit = (off32 < used32);
        peek_sum = 32'(rp_reg) + off32;
        cnt_inc  = (run_cnt_reg != '1) ? (run_cnt_reg + 1'b1) : run_cnt_reg;
        ack_cnt  = full ? run_cnt_reg : cnt_inc;
    end

    // Puts wait while a get still has bytes to read, so a freed slot is never overwritten early.
    assign in_stall = q_full || ((act == brfp_pkg::KIND_PUT) && read_busy);
    assign accept   = in_valid && !in_stall;
    assign wr_addr  = wp_reg[AW-1:0];
    assign wr_data  = data_byte;

    // Classify the word, update the pointers and build the command.
    always_comb
    begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        run_cnt_next = run_cnt_reg;
        wr_en        = 1'b0;
        push         = 1'b0;
        cmd_addr     = rp_reg[AW-1:0];
        cmd.kind     = act;
        cmd.is_read  = 1'b0;
        cmd.count    = brfp_pkg::REQ_W'(1);
        cmd.amount   = used32[brfp_pkg::CNT_W-1:0];
        cmd.free     = '0;
        if (accept)
        begin
            unique case (act)
                brfp_pkg::KIND_PUT:
                begin
                    if (!full)
                    begin
                        wr_en   = 1'b1;
                        wp_next = wp_reg + 1'b1;
                    end
                    cmd.amount = ack_cnt;
                    if (put_last)
                    begin
                        push         = 1'b1;
                        run_cnt_next = '0;
                    end
                    else
                    begin
                        run_cnt_next = ack_cnt;
                    end
                end
                brfp_pkg::KIND_GET:
                begin
                    push       = 1'b1;
                    cmd.amount = brfp_pkg::CNT_W'(n);
                    if (n != '0)
                    begin
                        cmd.is_read = 1'b1;
                        cmd.count   = n;
                        rp_next     = rp_reg + PTR_W'(n);
                        // A get that drains the store sends both pointers home.
                        if (rp_next == wp_reg)
                        begin
                            rp_next = '0;
                            wp_next = '0;
                        end
                    end
                end
                brfp_pkg::KIND_PEEK:
                begin
                    push        = 1'b1;
                    cmd.is_read = peek_hit;
                    cmd_addr    = peek_sum[AW-1:0];
                end
                brfp_pkg::KIND_STATUS:
                begin
                    push = 1'b1;
                end
            endcase
        end
        // Free space is reported as it stands after the word has acted.
        used_after = wp_next - rp_next;
        free32     = 32'(DEPTH) - 32'(used_after);
        cmd.free   = free32[brfp_pkg::CNT_W-1:0];
    end

    // Pointer and run-count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            run_cnt_reg <= '0;
        end
        else
        begin
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            run_cnt_reg <= run_cnt_next;
        end
    end

`ifndef SYNTH
    // Occupancy never exceeds the store size.
    assert property (@(posedge clk) disable iff (!rst_n) 32'(used) <= 32'(DEPTH))
        else $error("brfp_front: occupancy beyond depth");
    // No put byte is written while a get still reads the store.
    assert property (@(posedge clk) disable iff (!rst_n) !(wr_en && read_busy))
        else $error("brfp_front: write during pending get");
`endif

endmodule

>>> hw/rtl/brfp_queue.sv
// Two-entry command queue between the front and back parts.
module brfp_queue #(
    parameter int unsigned AW = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  brfp_pkg::cmd_t  push_cmd,
    input  logic [AW-1:0]   push_addr,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output brfp_pkg::cmd_t  head_cmd,
    output logic [AW-1:0]   head_addr,
    output logic            holds_get
);

    brfp_pkg::cmd_t q_cmd_reg  [2];
    logic [AW-1:0]  q_addr_reg [2];
    logic           q_vld_reg  [2];
    logic           wr_idx_reg;
    logic           rd_idx_reg;
    logic [1:0]     count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = q_cmd_reg[rd_idx_reg];
    assign head_addr  = q_addr_reg[rd_idx_reg];

    // A queued get that still has bytes to read holds back later puts.
    always_comb
    begin
        holds_get = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            if (q_vld_reg[i] && q_cmd_reg[i].is_read && (q_cmd_reg[i].kind == brfp_pkg::KIND_GET))
            begin
                holds_get = 1'b1;
            end
        end
    end

    // Entry payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cmd_reg[wr_idx_reg]  <= push_cmd;
            q_addr_reg[wr_idx_reg] <= push_addr;
        end
    end

    // Indices, fill count and per-entry valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg   <= 1'b0;
            rd_idx_reg   <= 1'b0;
            count_reg    <= 2'd0;
            q_vld_reg[0] <= 1'b0;
            q_vld_reg[1] <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                q_vld_reg[rd_idx_reg] <= 1'b0;
                rd_idx_reg            <= ~rd_idx_reg;
            end
            if (push)
            begin
                q_vld_reg[wr_idx_reg] <= 1'b1;
                wr_idx_reg            <= ~wr_idx_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("brfp_queue: push while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("brfp_queue: pop while empty");
`endif

endmodule

>>> hw/rtl/brfp_back.sv
// Back part: steps through commands, reads the store and drives the result words.
module brfp_back #(
    parameter int unsigned AW = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  brfp_pkg::cmd_t                q_cmd,
    input  logic [AW-1:0]                 q_addr,
    output logic                          q_pop,
    output logic                          busy_get,
    output logic                          ram_re,
    output logic [AW-1:0]                 ram_raddr,
    input  logic [brfp_pkg::BYTE_W-1:0]   ram_rdata,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    result_kind,
    output logic [brfp_pkg::BYTE_W-1:0]   out_byte,
    output logic                          byte_valid,
    output logic [brfp_pkg::CNT_W-1:0]    amount,
    output logic [brfp_pkg::CNT_W-1:0]    free_space,
    output logic                          run_last
);

    // Sequencer holding the command in progress.
    logic                          seq_valid_reg;
    brfp_pkg::cmd_t                seq_cmd_reg;
    logic [AW-1:0]                 seq_addr_reg;

    // Stage aligned with the registered RAM read.
    logic                          s1_valid_reg;
    brfp_pkg::kind_t               s1_kind_reg;
    logic                          s1_read_reg;
    logic [brfp_pkg::CNT_W-1:0]    s1_amount_reg;
    logic [brfp_pkg::CNT_W-1:0]    s1_free_reg;
    logic                          s1_last_reg;

    // Output register.
    logic                          out_valid_reg;
    brfp_pkg::kind_t               out_kind_reg;
    logic [brfp_pkg::BYTE_W-1:0]   out_byte_reg;
    logic                          out_bv_reg;
    logic [brfp_pkg::CNT_W-1:0]    out_amount_reg;
    logic [brfp_pkg::CNT_W-1:0]    out_free_reg;
    logic                          out_last_reg;

    logic out_ready;
    logic s1_adv;
    logic s1_free;
    logic seq_step;
    logic seq_final;
    logic seq_load;

    // Advance conditions, from the output back toward the queue.
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_ready;
    assign s1_free   = !s1_valid_reg || s1_adv;
    assign seq_step  = seq_valid_reg && s1_free;
    assign seq_final = (seq_cmd_reg.count == brfp_pkg::REQ_W'(1));
    assign seq_load  = q_valid && (!seq_valid_reg || (seq_step && seq_final));
    assign q_pop     = seq_load;
    assign busy_get  = seq_valid_reg && seq_cmd_reg.is_read
                       && (seq_cmd_reg.kind == brfp_pkg::KIND_GET);
    assign ram_re    = seq_step && seq_cmd_reg.is_read;
    assign ram_raddr = seq_addr_reg;

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = out_bv_reg;
    assign amount      = out_amount_reg;
    assign free_space  = out_free_reg;
    assign run_last    = out_last_reg;

    // Payload registers of all three steps.
    always_ff @(posedge clk)
    begin
        if (seq_load)
        begin
            seq_cmd_reg  <= q_cmd;
            seq_addr_reg <= q_addr;
        end
        else if (seq_step)
        begin
            seq_cmd_reg.count <= seq_cmd_reg.count - 1'b1;
            seq_addr_reg      <= seq_addr_reg + 1'b1;
        end
        if (seq_step)
        begin
            s1_kind_reg   <= seq_cmd_reg.kind;
            s1_read_reg   <= seq_cmd_reg.is_read;
            s1_amount_reg <= seq_cmd_reg.amount;
            s1_free_reg   <= seq_cmd_reg.free;
            s1_last_reg   <= seq_final;
        end
        if (s1_adv)
        begin
            out_kind_reg   <= s1_kind_reg;
            out_byte_reg   <= s1_read_reg ? ram_rdata : '0;
            out_bv_reg     <= s1_read_reg;
            out_amount_reg <= s1_amount_reg;
            out_free_reg   <= s1_free_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

    // Valid flags of the three steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (seq_load)
            begin
                seq_valid_reg <= 1'b1;
            end
            else if (seq_step && seq_final)
            begin
                seq_valid_reg <= 1'b0;
            end
            if (seq_step)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    // A live command always has at least one result left.
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_valid_reg |-> (seq_cmd_reg.count != '0))
        else $error("brfp_back: live command with zero count");
    // Every RAM read lands in the aligned stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) ram_re |=> (s1_valid_reg && s1_read_reg))
        else $error("brfp_back: read data not captured");
`endif

endmodule

>>> hw/rtl/byte_ring_fifo_with_peek.sv
// Byte ring FIFO with peek: front part, command queue, byte store and back part.
//
// Input channel (in_valid/in_stall) takes one word per cycle while in_stall is low: a put
// byte, a get run, a peek at an offset from the read position, or a status query. A put run
// produces one acknowledge word on its byte marked put_last. Every other word produces results.
// Output channel (out_valid/out_stall) delivers result words; a get run gives one word
// per byte, one per cycle while out_stall is low, with run_last on its final byte. A get
// from an empty store or with zero count gives a single word with byte_valid low.
// From acceptance, each word passes the command queue register, the sequencer, the stage
// that captures the registered store read and the output register before its first result
// word appears. Puts, peeks and status words are taken at one per cycle while in_stall is
// low; the back part steps through a get one byte at a time. A put word is held off while
// a get still has bytes to read from the store, since the get frees those slots at acceptance.
// The command queue holds two words, so the input stalls once the output has been
// stalled long enough to fill it. A stalled output word holds its value.
// Reset empties the store (both pointers zero), clears the put run count and drops all
// words in flight. The store contents themselves are not cleared.
module byte_ring_fifo_with_peek #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned MAX_RUN = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [brfp_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          put_last,
    input  logic [brfp_pkg::REQ_W-1:0]    request_count,
    input  logic [brfp_pkg::OFF_W-1:0]    peek_offset,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    result_kind,
    output logic [brfp_pkg::BYTE_W-1:0]   out_byte,
    output logic                          byte_valid,
    output logic [brfp_pkg::CNT_W-1:0]    amount,
    output logic [brfp_pkg::CNT_W-1:0]    free_space,
    output logic                          run_last
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic                        q_full;
    logic                        push;
    brfp_pkg::cmd_t              push_cmd;
    logic [AW-1:0]               push_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [brfp_pkg::BYTE_W-1:0] wr_data;
    logic                        q_pop;
    logic                        head_valid;
    brfp_pkg::cmd_t              head_cmd;
    logic [AW-1:0]               head_addr;
    logic                        q_holds_get;
    logic                        back_busy_get;
    logic                        read_busy;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [brfp_pkg::BYTE_W-1:0] ram_rdata;

    assign read_busy = q_holds_get || back_busy_get;

    // Front part: accept, classify, pointer update and put writes.
    brfp_front #(
        .DEPTH   (DEPTH),
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .data_byte     (data_byte),
        .put_last      (put_last),
        .request_count (request_count),
        .peek_offset   (peek_offset),
        .q_full        (q_full),
        .read_busy     (read_busy),
        .push          (push),
        .cmd           (push_cmd),
        .cmd_addr      (push_addr),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    // Command queue between the two parts.
    brfp_queue #(
        .AW (AW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_addr  (push_addr),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_addr  (head_addr),
        .holds_get  (q_holds_get)
    );

    // Byte store.
    brfp_ram #(
        .WIDTH (brfp_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Back part: store reads and result words.
    brfp_back #(
        .AW (AW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (head_valid),
        .q_cmd       (head_cmd),
        .q_addr      (head_addr),
        .q_pop       (q_pop),
        .busy_get    (back_busy_get),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .amount      (amount),
        .free_space  (free_space),
        .run_last    (run_last)
    );

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the byte ring FIFO with peek.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;
    localparam int MAX_RUN = 64;
    localparam int ITEM_TARGET = 100;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 20;

    // One result word as seen on the output port.
    typedef struct {
        brfp_pkg::kind_t            kind;
        logic [7:0]                 data;
        logic                       vld;
        logic [brfp_pkg::CNT_W-1:0] amt;
        logic [brfp_pkg::CNT_W-1:0] free;
        logic                       lst;
    } fifo_word_t;

    // Tracks the FIFO contents and the result words they must produce.
    class fifo_scoreboard;
        logic [7:0]                 store_mem [DEPTH];
        logic [brfp_pkg::CNT_W-1:0] wr_ptr;
        logic [brfp_pkg::CNT_W-1:0] rd_ptr;
        logic [brfp_pkg::CNT_W-1:0] run_count;
        fifo_word_t                 pending [$];
        int                         errors;

        function new();
            wr_ptr = '0;
            rd_ptr = '0;
            run_count = '0;
            errors = 0;
        endfunction

        // Pointers run modulo twice the depth, which the 11-bit width gives for free.
        function logic [brfp_pkg::CNT_W-1:0] used_bytes();
            return wr_ptr - rd_ptr;
        endfunction

        function void add(brfp_pkg::kind_t kind, logic [7:0] data, logic vld,
                          logic [brfp_pkg::CNT_W-1:0] amt, logic lst);
            fifo_word_t w;
            w.kind = kind;
            w.data = data;
            w.vld = vld;
            w.amt = amt;
            w.free = brfp_pkg::CNT_W'(DEPTH) - used_bytes();
            w.lst = lst;
            pending.push_back(w);
        endfunction

        // Apply one accepted input word and queue the result words it causes.
        function void note_input(brfp_pkg::kind_t act, logic [7:0] data, logic lst,
                                 logic [6:0] req, logic [9:0] off);
            logic [brfp_pkg::CNT_W-1:0] used;
            int n;
            logic [7:0] got [MAX_RUN];
            used = used_bytes();
            case (act)
                brfp_pkg::KIND_PUT:
                begin
                    // A full store drops the byte without counting it.
                    if (used < DEPTH)
                    begin
                        store_mem[int'(wr_ptr) % DEPTH] = data;
                        wr_ptr = wr_ptr + 1'b1;
                        if (run_count != '1)
                            run_count = run_count + 1'b1;
                    end
                    if (lst)
                    begin
                        add(brfp_pkg::KIND_PUT, 8'd0, 1'b0, run_count, 1'b1);
                        run_count = '0;
                    end
                end
                brfp_pkg::KIND_GET:
                begin
                    n = (int'(req) > MAX_RUN) ? MAX_RUN : int'(req);
                    if (n > int'(used))
                        n = int'(used);
                    if (n == 0)
                        add(brfp_pkg::KIND_GET, 8'd0, 1'b0, '0, 1'b1);
                    else
                    begin
                        for (int i = 0; i < n; i++)
                        begin
                            got[i] = store_mem[int'(rd_ptr) % DEPTH];
                            rd_ptr = rd_ptr + 1'b1;
                        end
                        // Emptying the store brings both pointers back to zero.
                        if (rd_ptr == wr_ptr)
                        begin
                            rd_ptr = '0;
                            wr_ptr = '0;
                        end
                        for (int i = 0; i < n; i++)
                            add(brfp_pkg::KIND_GET, got[i], 1'b1, brfp_pkg::CNT_W'(n),
                                i == n - 1);
                    end
                end
                brfp_pkg::KIND_PEEK:
                begin
                    if (off < used)
                        add(brfp_pkg::KIND_PEEK,
                            store_mem[(int'(rd_ptr) + int'(off)) % DEPTH], 1'b1,
                            used, 1'b1);
                    else
                        add(brfp_pkg::KIND_PEEK, 8'd0, 1'b0, used, 1'b1);
                end
                default:
                    add(brfp_pkg::KIND_STATUS, 8'd0, 1'b0, used, 1'b1);
            endcase
        endfunction

        function void flag(string field, logic [31:0] exp_v, logic [31:0] act_v);
            errors++;
            if (errors <= 10)
                $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field,
                         exp_v, act_v);
        endfunction

        // Compare one accepted result word with the oldest expected one.
        function void check_result(fifo_word_t act);
            fifo_word_t exp;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result word with none expected (kind %0d)", $realtime,
                             act.kind);
                return;
            end
            exp = pending.pop_front();
            if (act.kind !== exp.kind)
                flag("result_kind", exp.kind, act.kind);
            if (act.data !== exp.data)
                flag("out_byte", exp.data, act.data);
            if (act.vld !== exp.vld)
                flag("byte_valid", exp.vld, act.vld);
            if (act.amt !== exp.amt)
                flag("amount", exp.amt, act.amt);
            if (act.free !== exp.free)
                flag("free_space", exp.free, act.free);
            if (act.lst !== exp.lst)
                flag("run_last", exp.lst, act.lst);
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [1:0]                 action = brfp_pkg::KIND_STATUS;
    logic [7:0]                 data_byte = '0;
    logic                       put_last = 1'b0;
    logic [6:0]                 request_count = '0;
    logic [9:0]                 peek_offset = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [1:0]                 result_kind;
    logic [7:0]                 out_byte;
    logic                       byte_valid;
    logic [brfp_pkg::CNT_W-1:0] amount;
    logic [brfp_pkg::CNT_W-1:0] free_space;
    logic                       run_last;

    fifo_scoreboard sb = new();
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  sender_calm = 1'b0;
    bit  recv_calm = 1'b0;

    byte_ring_fifo_with_peek #(
        .DEPTH(DEPTH),
        .MAX_RUN(MAX_RUN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .data_byte(data_byte),
        .put_last(put_last),
        .request_count(request_count),
        .peek_offset(peek_offset),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_kind(result_kind),
        .out_byte(out_byte),
        .byte_valid(byte_valid),
        .amount(amount),
        .free_space(free_space),
        .run_last(run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Cycle limit for a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: check accepted words and stall at random, with calm stretches.
    always @(posedge clk)
    begin
        fifo_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            w.kind = brfp_pkg::kind_t'(result_kind);
            w.data = out_byte;
            w.vld = byte_valid;
            w.amt = amount;
            w.free = free_space;
            w.lst = run_last;
            sb.check_result(w);
        end
        if (cycle_count % 256 == 0)
            recv_calm = ($urandom_range(0, 2) == 0);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (!recv_calm && $urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = pick_pause();
        end
        else
            out_stall <= 1'b0;
    end

    // Offer one word, hold it until accepted, then maybe pause.
    task automatic send_word(brfp_pkg::kind_t act, logic [7:0] data, logic lst,
                             logic [6:0] req, logic [9:0] off);
        int pause;
        in_valid <= 1'b1;
        action <= act;
        data_byte <= data;
        put_last <= lst;
        request_count <= req;
        peek_offset <= off;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(act, data, lst, req, off);
        pause = sender_calm ? 0 : pick_pause();
        if (pause > 0)
        begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
    endtask

    // Fields that an action ignores still carry random values.
    task automatic do_put(logic [7:0] data, logic lst);
        send_word(brfp_pkg::KIND_PUT, data, lst, 7'($urandom_range(0, 127)),
                  10'($urandom_range(0, 1023)));
    endtask

    task automatic do_get(logic [6:0] req);
        send_word(brfp_pkg::KIND_GET, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), req, 10'($urandom_range(0, 1023)));
    endtask

    task automatic do_peek(logic [9:0] off);
        send_word(brfp_pkg::KIND_PEEK, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), off);
    endtask

    task automatic do_status();
        send_word(brfp_pkg::KIND_STATUS, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                  10'($urandom_range(0, 1023)));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Empty store cases, extreme bytes and offsets, clamping and the zero count.
    task automatic run_directed();
        do_status();
        do_get(7'd0);
        do_get(7'd5);
        do_peek(10'd0);
        do_peek(10'd1023);
        do_put(8'h00, 1'b0);
        do_put(8'hFF, 1'b0);
        do_put(8'hA5, 1'b1);
        do_put(8'h5A, 1'b1);
        do_peek(10'd0);
        do_peek(10'd3);
        do_peek(10'd4);
        do_peek(10'd1023);
        do_get(7'd0);
        do_get(7'd2);
        do_status();
        do_get(7'd127);
        do_status();
        do_get(7'd64);
        do_peek(10'd0);
    endtask

    // Random mix of put runs, gets, peeks and status words.
    task automatic run_random();
        int items;
        int r;
        int len;
        bit paused;
        items = 0;
        paused = 1'b0;
        while (items < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    do_put(8'($urandom_range(0, 255)), k == len - 1);
                items += len;
            end
            else if (r < 70)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    do_get(7'd0);
                else if (r < 75)
                    do_get(7'($urandom_range(1, 16)));
                else if (r < 90)
                    do_get(7'($urandom_range(17, 64)));
                else
                    do_get(7'($urandom_range(65, 127)));
                items++;
            end
            else if (r < 90)
            begin
                if (sb.used_bytes() != 0 && $urandom_range(0, 9) < 7)
                    do_peek(10'($urandom_range(0, int'(sb.used_bytes()) - 1)));
                else
                    do_peek(10'($urandom_range(0, 1023)));
                items++;
            end
            else
            begin
                do_status();
                items++;
            end
            // Halfway through, let every pending result come out first.
            if (items >= ITEM_TARGET / 2 && !paused)
            begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 14) == 0)
                sender_calm = !sender_calm;
        end
    endtask

    // Reset, stimulus, drain and verdict.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0)
            $display("%0d expected result words never arrived", sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
